FILE: hdl/dpts_pkg.sv
// Shared constants, types and helper functions of the dual-pattern trigger sequencer.
package dpts_pkg;

  localparam int Steps      = 8;
  localparam int TimerWidth = 16;
  localparam int StepW      = $clog2(Steps + 1);
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int PatW       = 8;

  localparam logic [1:0] ModeClock = 2'd0;
  localparam logic [1:0] ModeGate  = 2'd1;
  localparam logic [1:0] ModeTrig  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgOutputMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEdgeWindow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTriggerLen  = 2'd2;

  typedef struct packed {
    logic edge_hit;
    logic rst_rise;
  } edge_info_t;

  // Loads a 16-bit register value into a timer, saturating at its maximum.
  function automatic logic [TimerWidth-1:0] timer_load(input logic [CfgDataW-1:0] v);
    logic [CfgDataW-1:0] upper;
    upper = v >> TimerWidth;
    if (TimerWidth >= CfgDataW) begin
      return TimerWidth'(v);
    end else if (upper != '0) begin
      return '1;
    end else begin
      return TimerWidth'(v);
    end
  endfunction

  // Step n tests pattern bit (Steps - n); step zero and bits past the pattern give 0.
  function automatic logic step_bit(input logic [PatW-1:0] pattern,
                                    input logic [StepW-1:0] step);
    logic res;
    int   idx;
    res = 1'b0;
    idx = Steps - int'(step);
    if (step != '0 && int'(step) <= Steps) begin
      for (int i = 0; i < PatW; i++) begin
        if (idx == i) begin
          res = pattern[i];
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: hdl/dpts_edge.sv
// Edge detection of the clock, reset and run levels, with the edge window timer.
module dpts_edge import dpts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  clock_level_i,
  input  logic                  reset_level_i,
  input  logic                  run_level_i,
  input  logic [CfgDataW-1:0]   edge_window_ticks_i,
  output edge_info_t            edge_o
);

  logic                  prev_clock_q, prev_reset_q, prev_run_q;
  logic [TimerWidth-1:0] window_q, window_d;
  logic                  clk_rise, rst_rise, run_rise, edge_hit;

  assign clk_rise = clock_level_i & ~prev_clock_q;
  assign rst_rise = reset_level_i & ~prev_reset_q;
  assign run_rise = run_level_i & ~prev_run_q;

  always_comb begin
    window_d = window_q;
    edge_hit = clk_rise;
    if (clk_rise) begin
      window_d = timer_load(edge_window_ticks_i);
    end else if (window_q != '0) begin
      window_d = window_q - 1'b1;
      edge_hit = run_rise | rst_rise;
    end
  end

  assign edge_o.edge_hit = edge_hit;
  assign edge_o.rst_rise = rst_rise;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clock_q <= 1'b0;
      prev_reset_q <= 1'b0;
      prev_run_q   <= 1'b0;
      window_q     <= '0;
    end else if (fire_i) begin
      prev_clock_q <= clock_level_i;
      prev_reset_q <= reset_level_i;
      prev_run_q   <= run_level_i;
      window_q     <= window_d;
    end
  end

endmodule

FILE: hdl/dpts_core.sv
// Step counter, pattern chaining and latching, and the output pulse logic.
module dpts_core import dpts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  edge_info_t            edge_i,
  input  logic                  clock_level_i,
  input  logic                  run_level_i,
  input  logic [PatW-1:0]       pattern_a_i,
  input  logic [PatW-1:0]       pattern_b_i,
  input  logic [1:0]            output_mode_i,
  input  logic [CfgDataW-1:0]   trigger_ticks_i,
  output logic                  trig_o,
  output logic [StepW-1:0]      step_count_o,
  output logic                  on_pattern_b_o,
  output logic [PatW-1:0]       latched_a_o,
  output logic [PatW-1:0]       latched_b_o
);

  logic [StepW-1:0]      step_q, step_d;
  logic                  second_q, second_d;
  logic                  active_q, active_d;
  logic [TimerWidth-1:0] pulse_q, pulse_d;
  logic [PatW-1:0]       sel_q, sel_d, held_a_q, held_a_d, held_b_q, held_b_d;
  logic                  bit_set, trig;

  always_comb begin
    step_d   = step_q;
    second_d = second_q;
    active_d = active_q & run_level_i;
    if (edge_i.rst_rise) begin
      step_d   = '0;
      second_d = 1'b0;
    end else if (edge_i.edge_hit && run_level_i) begin
      active_d = 1'b1;
      if (step_q == StepW'(Steps)) begin
        step_d   = StepW'(1);
        second_d = ~second_q;
      end else begin
        step_d = step_q + 1'b1;
      end
    end

    held_a_d = held_a_q;
    held_b_d = held_b_q;
    sel_d    = sel_q;
    if (edge_i.edge_hit) begin
      held_a_d = pattern_a_i;
      held_b_d = pattern_b_i;
      sel_d    = second_d ? pattern_b_i : pattern_a_i;
    end

    bit_set = step_bit(sel_d, step_d);
    pulse_d = pulse_q;
    trig    = 1'b0;
    case (output_mode_i)
      ModeClock: trig = active_d & clock_level_i & bit_set;
      ModeGate:  trig = active_d & bit_set;
      ModeTrig: begin
        if (active_d && edge_i.edge_hit && bit_set) begin
          pulse_d = timer_load(trigger_ticks_i);
          trig    = 1'b1;
        end else if (pulse_q != '0) begin
          pulse_d = pulse_q - 1'b1;
          trig    = 1'b1;
        end
      end
      default: trig = 1'b0;
    endcase
  end

  assign trig_o         = trig;
  assign step_count_o   = step_d;
  assign on_pattern_b_o = second_d;
  assign latched_a_o    = held_a_d;
  assign latched_b_o    = held_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      second_q <= 1'b0;
      active_q <= 1'b0;
      pulse_q  <= '0;
      sel_q    <= '0;
      held_a_q <= '0;
      held_b_q <= '0;
    end else if (fire_i) begin
      step_q   <= step_d;
      second_q <= second_d;
      active_q <= active_d;
      pulse_q  <= pulse_d;
      sel_q    <= sel_d;
      held_a_q <= held_a_d;
      held_b_q <= held_b_d;
    end
  end

endmodule

FILE: hdl/dual_pattern_trigger_sequencer_top.sv
// Top level of the dual-pattern trigger sequencer: channels, registers and stages.
//
//   Channel  Direction  Handshake               Contents
//   in       input      in_valid_i / in_stall_o   one sample tick: levels and patterns
//   out      output     out_valid_o / out_stall_i one result item per tick
//   cfg      input      cfg_valid_i / cfg_ready_o register index and write data
//
// Each item is taken into an input register, worked on by the edge and step logic
// combinationally, and lands in the result register; one item per cycle without
// output stalls. The edge and step state advance only when the item in the
// input register moves into the result register. Reset clears all sequencer state,
// both valid flags and restores the registers to their defaults. A stall on the
// output holds the result register and, once the input register is full, the input.
module dual_pattern_trigger_sequencer_top import dpts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                clock_level_i,
  input  logic                reset_level_i,
  input  logic                run_level_i,
  input  logic [PatW-1:0]     pattern_a_i,
  input  logic [PatW-1:0]     pattern_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                trig_out_o,
  output logic [3:0]          step_index_o,
  output logic                on_pattern_b_o,
  output logic                clock_edge_seen_o,
  output logic [PatW-1:0]     latched_a_o,
  output logic [PatW-1:0]     latched_b_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers; an index outside the list is accepted and dropped.
  logic [1:0]          output_mode_q;
  logic [CfgDataW-1:0] edge_window_q, trigger_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_mode_q   <= ModeClock;
      edge_window_q   <= CfgDataW'(5);
      trigger_ticks_q <= CfgDataW'(48);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgOutputMode: output_mode_q   <= cfg_data_i[1:0];
        CfgEdgeWindow: edge_window_q   <= cfg_data_i;
        CfgTriggerLen: trigger_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register. The held item moves on whenever the result register is free
  // or being emptied, so a new item may enter in the same cycle.
  logic            in_valid_q;
  logic            clock_q, reset_q, run_q;
  logic [PatW-1:0] pat_a_q, pat_b_q;
  logic            out_valid_q, fire, out_free;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign fire       = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      clock_q <= clock_level_i;
      reset_q <= reset_level_i;
      run_q   <= run_level_i;
      pat_a_q <= pattern_a_i;
      pat_b_q <= pattern_b_i;
    end
  end

  // Sequencer logic.
  edge_info_t       edge_info;
  logic             trig;
  logic [StepW-1:0] step_count;
  logic             on_b;
  logic [PatW-1:0]  held_a, held_b;

  dpts_edge u_edge (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .fire_i              (fire),
    .clock_level_i       (clock_q),
    .reset_level_i       (reset_q),
    .run_level_i         (run_q),
    .edge_window_ticks_i (edge_window_q),
    .edge_o              (edge_info)
  );

  dpts_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .edge_i          (edge_info),
    .clock_level_i   (clock_q),
    .run_level_i     (run_q),
    .pattern_a_i     (pat_a_q),
    .pattern_b_i     (pat_b_q),
    .output_mode_i   (output_mode_q),
    .trigger_ticks_i (trigger_ticks_q),
    .trig_o          (trig),
    .step_count_o    (step_count),
    .on_pattern_b_o  (on_b),
    .latched_a_o     (held_a),
    .latched_b_o     (held_b)
  );

  // Result register.
  logic            trig_q, on_b_q, edge_seen_q;
  logic [3:0]      step_index_q;
  logic [PatW-1:0] lat_a_q, lat_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      trig_q       <= trig;
      step_index_q <= 4'(step_count);
      on_b_q       <= on_b;
      edge_seen_q  <= edge_info.edge_hit;
      lat_a_q      <= held_a;
      lat_b_q      <= held_b;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign trig_out_o        = trig_q;
  assign step_index_o      = step_index_q;
  assign on_pattern_b_o    = on_b_q;
  assign clock_edge_seen_o = edge_seen_q;
  assign latched_a_o       = lat_a_q;
  assign latched_b_o       = lat_b_q;

endmodule
